[rtl/go_back_n_sender_window_macros.svh]
// ----------------------------------------------------------------------------
// Go-Back-N sender window assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_WINDOW_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_MACROS_SVH

// property must hold at every edge out of reset
`define GBN_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define GBN_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gbn_pkg.sv]
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants of the Go-Back-N sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int MAX_PACKETS = 256;
    localparam int MAX_WINDOW  = 32;

    localparam int SEQ_W  = $clog2(MAX_PACKETS);
    localparam int CNT_W  = SEQ_W + 1;
    localparam int WIN_W  = 6;
    localparam int TMO_W  = 16;
    localparam int TICK_W = 32;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_COUNT  = 2'd2;

    localparam logic [WIN_W-1:0] WINDOW_SIZE_RST   = 6'd4;
    localparam logic [TMO_W-1:0] TIMEOUT_TICKS_RST = 16'd1000;
    localparam logic [CNT_W-1:0] PACKET_COUNT_RST  = 9'd10;

    localparam logic [WIN_W-1:0] WIN_CAP   = WIN_W'(MAX_WINDOW);
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(MAX_PACKETS);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ACK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_SEND,
        ST_FIN
    } gbn_state_t;

    typedef struct packed {
        logic              we;
        logic [SEQ_W-1:0]  waddr;
        logic [TICK_W-1:0] wdata;
        logic              re;
        logic [SEQ_W-1:0]  raddr;
    } gbn_ram_req_t;

endpackage

[rtl/gbn_deadline_ram.sv]
// ----------------------------------------------------------------------------
// gbn_deadline_ram
// Per-packet deadline store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbn_deadline_ram (
    input  logic                        clk,
    input  gbn_pkg::gbn_ram_req_t       req,
    output logic [gbn_pkg::TICK_W-1:0] rdata
);
    import gbn_pkg::*;

    logic [TICK_W-1:0] mem [MAX_PACKETS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

[rtl/go_back_n_sender_window.sv]
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Go-Back-N ARQ sender window with one retransmit deadline per packet.
// ----------------------------------------------------------------------------
// Each input transfer is a tick or an acknowledgement. After applying it the
// block walks the window once through the deadline RAM read port, one packet
// per cycle while the output is not stalled: in-flight packets whose deadline
// has passed are re-sent, then new packets are sent until the window is full
// or the packet count is reached. The input is stalled until the item's last
// result has been placed in the output register; that register lets the next
// item start while the final result still waits to be taken.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_window_macros.svh"

module go_back_n_sender_window (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbn_pkg::CFG_W-1:0]      cfg_data,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic [gbn_pkg::SEQ_W-1:0]      ack_seq,
    input  logic                           ack_corrupt,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           send_valid,
    output logic [gbn_pkg::SEQ_W-1:0]      send_seq,
    output logic                           is_retransmit,
    output logic [gbn_pkg::CNT_W-1:0]      window_base,
    output logic                           all_done,
    output logic                           last
);
    import gbn_pkg::*;

    gbn_state_t state_reg, state_next;

    logic [WIN_W-1:0]  window_size_reg;
    logic [TMO_W-1:0]  timeout_ticks_reg;
    logic [CNT_W-1:0]  packet_count_reg;

    logic [CNT_W-1:0]  base_seq_reg, next_seq_reg;
    logic [TICK_W-1:0] now_reg;

    logic [CNT_W-1:0]  limit_reg, scan_end_reg, rd_idx_reg;
    logic [SEQ_W-1:0]  chk_idx_reg;
    logic              chk_valid_reg;
    logic [TICK_W-1:0] fresh_reg;
    logic              done_reg;

    logic              held_valid_reg;
    logic [SEQ_W-1:0]  held_seq_reg;
    logic              held_retx_reg;

    logic              out_valid_reg;
    logic              send_valid_reg, is_retransmit_reg, all_done_reg, last_reg;
    logic [SEQ_W-1:0]  send_seq_reg;
    logic [CNT_W-1:0]  window_base_reg;

    logic [WIN_W-1:0]  win_eff;
    logic [CNT_W-1:0]  count_eff;
    logic              accept;
    logic              ack_ok;
    logic [CNT_W-1:0]  ack_ext, ack_base;
    logic [CNT_W:0]    limit_sum;
    logic [CNT_W-1:0]  limit_calc;

    logic [TICK_W-1:0] rdata;
    logic [TICK_W-1:0] diff;
    logic              expired;
    logic              out_free, push_ok, scan_more;
    logic              scan_adv, scan_hit, send_go, fin_go;
    gbn_ram_req_t      ram_req;

    gbn_deadline_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    assign win_eff   = (window_size_reg > WIN_CAP) ? WIN_CAP : window_size_reg;
    assign count_eff = (packet_count_reg > COUNT_CAP) ? COUNT_CAP : packet_count_reg;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    assign ack_ext  = {1'b0, ack_seq};
    assign ack_base = ack_ext + CNT_W'(1);
    assign ack_ok   = (operation == OP_ACK) && !ack_corrupt &&
                      (ack_ext >= base_seq_reg) && (ack_ext < count_eff);

    assign limit_sum  = {1'b0, base_seq_reg} + (CNT_W+1)'(win_eff);
    assign limit_calc = (limit_sum > {1'b0, count_eff}) ? count_eff
                                                        : limit_sum[CNT_W-1:0];

    assign diff      = now_reg - rdata;
    assign expired   = chk_valid_reg && (diff != '0) && !diff[TICK_W-1];
    assign out_free  = !out_valid_reg || !out_stall;
    assign push_ok   = !held_valid_reg || out_free;
    assign scan_more = rd_idx_reg < scan_end_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_adv && !scan_more)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (next_seq_reg >= limit_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        scan_adv      = 1'b0;
        scan_hit      = 1'b0;
        send_go       = 1'b0;
        fin_go        = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.waddr = chk_idx_reg;
        ram_req.wdata = fresh_reg;
        ram_req.re    = 1'b0;
        ram_req.raddr = rd_idx_reg[SEQ_W-1:0];
        unique case (state_reg)
            ST_SCAN:
            begin
                scan_adv   = !expired || push_ok;
                scan_hit   = scan_adv && expired;
                ram_req.we = scan_hit;
                ram_req.re = scan_adv && scan_more;
            end
            ST_SEND:
            begin
                send_go       = (next_seq_reg < limit_reg) && push_ok;
                ram_req.we    = send_go;
                ram_req.waddr = next_seq_reg[SEQ_W-1:0];
            end
            ST_FIN:
            begin
                fin_go = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg   <= WINDOW_SIZE_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
            packet_count_reg  <= PACKET_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_SIZE:   window_size_reg   <= cfg_data[WIN_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[TMO_W-1:0];
                CFG_PACKET_COUNT:  packet_count_reg  <= cfg_data[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_seq_reg   <= '0;
            next_seq_reg   <= '0;
            now_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                if (operation == OP_TICK)
                begin
                    now_reg <= now_reg + TICK_W'(1);
                end
                else if (ack_ok)
                begin
                    base_seq_reg <= ack_base;
                    if (next_seq_reg < ack_base)
                    begin
                        next_seq_reg <= ack_base;
                    end
                end
            end

            if (state_reg == ST_PREP)
            begin
                chk_valid_reg <= 1'b0;
            end
            else if (scan_adv)
            begin
                chk_valid_reg <= scan_more;
            end

            if (send_go)
            begin
                next_seq_reg <= next_seq_reg + CNT_W'(1);
            end

            if (scan_hit || send_go)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (fin_go)
            begin
                held_valid_reg <= 1'b0;
            end

            if (((scan_hit || send_go) && held_valid_reg) || fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PREP)
        begin
            limit_reg    <= limit_calc;
            scan_end_reg <= (limit_calc < next_seq_reg) ? limit_calc : next_seq_reg;
            rd_idx_reg   <= base_seq_reg;
            fresh_reg    <= now_reg + TICK_W'(timeout_ticks_reg);
            done_reg     <= (base_seq_reg >= count_eff);
        end
        else if (ram_req.re)
        begin
            rd_idx_reg  <= rd_idx_reg + CNT_W'(1);
            chk_idx_reg <= rd_idx_reg[SEQ_W-1:0];
        end

        if (scan_hit)
        begin
            held_seq_reg  <= chk_idx_reg;
            held_retx_reg <= 1'b1;
        end
        else if (send_go)
        begin
            held_seq_reg  <= next_seq_reg[SEQ_W-1:0];
            held_retx_reg <= 1'b0;
        end

        if (((scan_hit || send_go) && held_valid_reg) || fin_go)
        begin
            send_valid_reg    <= held_valid_reg;
            send_seq_reg      <= held_valid_reg ? held_seq_reg : '0;
            is_retransmit_reg <= held_valid_reg && held_retx_reg;
            window_base_reg   <= base_seq_reg;
            all_done_reg      <= done_reg;
            last_reg          <= fin_go;
        end
    end

    assign out_valid     = out_valid_reg;
    assign send_valid    = send_valid_reg;
    assign send_seq      = send_seq_reg;
    assign is_retransmit = is_retransmit_reg;
    assign window_base   = window_base_reg;
    assign all_done      = all_done_reg;
    assign last          = last_reg;

    `GBN_ASSERT_ALWAYS(a_base_le_next, base_seq_reg <= next_seq_reg,
                       "base passed next_seq")
    `GBN_ASSERT_IMPLY(a_chk_in_flight, chk_valid_reg,
                      ({1'b0, chk_idx_reg} < next_seq_reg), "checked packet not in flight")
    `GBN_ASSERT_IMPLY(a_idle_empty, state_reg == ST_IDLE,
                      !held_valid_reg && !chk_valid_reg, "pending result left in idle")
    `GBN_ASSERT_NEXT(a_fin_last, fin_go, out_valid_reg && last_reg,
                     "final result not marked last")

endmodule

[sim/go_back_n_sender_window_tb.sv]
// ----------------------------------------------------------------------------
// go_back_n_sender_window_tb
// Self-checking bench for the Go-Back-N sender window. A directed table of
// ticks, acks and register writes runs first, then random sessions of mostly
// in-order acks and ticks under bursty input and patterned output stall. Each
// transfer out of the block is checked against a window predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module go_back_n_sender_window_tb;
    import gbn_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE       = MAX_WINDOW + 8;
    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 80;
    localparam int SHOW_MAX     = 10;

    typedef struct packed {
        logic             sv;
        logic [SEQ_W-1:0] seq;
        logic             rt;
        logic [CNT_W-1:0] base;
        logic             done;
        logic             last;
    } send_rec_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic                 quiet;
        logic                 op;
        logic [SEQ_W-1:0]     seq;
        logic                 bad;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        logic [CNT_W-1:0]     base;
        logic                 done;
    } row_t;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 operation;
    logic [SEQ_W-1:0]     ack_seq;
    logic                 ack_corrupt;
    logic                 out_valid;
    logic                 out_stall;
    logic                 send_valid;
    logic [SEQ_W-1:0]     send_seq;
    logic                 is_retransmit;
    logic [CNT_W-1:0]     window_base;
    logic                 all_done;
    logic                 last;

    // predictor state
    logic [WIN_W-1:0]  win_cfg;
    logic [TMO_W-1:0]  tmo_cfg;
    logic [CNT_W-1:0]  cnt_cfg;
    int unsigned       oldest_unacked;
    int unsigned       next_fresh;
    logic [TICK_W-1:0] tick_now;
    logic              in_air [MAX_PACKETS];
    logic [TICK_W-1:0] due_tick [MAX_PACKETS];

    send_rec_t   step_sends [$];
    send_rec_t   pending_sends [$];
    row_t        plan [$];
    int unsigned fail_count;
    int unsigned shown;
    int unsigned idle_cycles;
    int unsigned burst_left;

    go_back_n_sender_window DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .ack_seq       (ack_seq),
        .ack_corrupt   (ack_corrupt),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .send_valid    (send_valid),
        .send_seq      (send_seq),
        .is_retransmit (is_retransmit),
        .window_base   (window_base),
        .all_done      (all_done),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int unsigned eff_packets();
        return (int'(cnt_cfg) > MAX_PACKETS) ? MAX_PACKETS : int'(cnt_cfg);
    endfunction

    function automatic send_rec_t make_rec(logic sv, int unsigned seq, logic rt, logic done);
        send_rec_t r;
        r.sv   = sv;
        r.seq  = SEQ_W'(seq);
        r.rt   = rt;
        r.base = CNT_W'(oldest_unacked);
        r.done = done;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void launch(int unsigned seq);
        in_air[seq]   = 1'b1;
        due_tick[seq] = tick_now + TICK_W'(tmo_cfg);
    endfunction

    function automatic void advance_window(logic op, logic [SEQ_W-1:0] seq, logic bad);
        int unsigned       count;
        int unsigned       span;
        int unsigned       lim;
        int unsigned       i;
        logic              done;
        logic [TICK_W-1:0] late;
        step_sends.delete();
        count = eff_packets();
        span  = (int'(win_cfg) > MAX_WINDOW) ? MAX_WINDOW : int'(win_cfg);
        if (op == OP_TICK)
            tick_now = tick_now + 1'b1;
        else if (!bad && int'(seq) >= oldest_unacked && int'(seq) < count)
        begin
            for (i = oldest_unacked; i <= int'(seq); i++)
                in_air[i] = 1'b0;
            oldest_unacked = int'(seq) + 1;
            if (next_fresh < oldest_unacked)
                next_fresh = oldest_unacked;
        end
        lim = oldest_unacked + span;
        if (lim > count)
            lim = count;
        done = (oldest_unacked >= count);
        for (i = oldest_unacked; i < lim; i++)
        begin
            if (in_air[i])
            begin
                late = tick_now - due_tick[i];
                if (late != '0 && !late[TICK_W-1])
                begin
                    launch(i);
                    step_sends.push_back(make_rec(1'b1, i, 1'b1, done));
                end
            end
        end
        while (next_fresh < lim)
        begin
            launch(next_fresh);
            step_sends.push_back(make_rec(1'b1, next_fresh, 1'b0, done));
            next_fresh++;
        end
        if (step_sends.size() == 0)
            step_sends.push_back(make_rec(1'b0, 0, 1'b0, done));
        step_sends[step_sends.size() - 1].last = 1'b1;
    endfunction

    function automatic row_t item_row(logic op, int unsigned seq, logic bad);
        row_t r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.op   = op;
        r.seq  = SEQ_W'(seq);
        r.bad  = bad;
        return r;
    endfunction

    // item that sends nothing: result known up front
    function automatic row_t quiet_row(logic op, int unsigned seq, logic bad,
                                       int unsigned base, logic done);
        row_t r;
        r       = item_row(op, seq, bad);
        r.quiet = 1'b1;
        r.base  = CNT_W'(base);
        r.done  = done;
        return r;
    endfunction

    function automatic row_t write_row(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        row_t r;
        r      = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.val  = CFG_W'(val);
        return r;
    endfunction

    function automatic bit pick_item(output logic op, output logic [SEQ_W-1:0] seq,
                                     output logic bad);
        int unsigned count;
        int unsigned top;
        int unsigned roll;
        int unsigned reach;
        count = eff_packets();
        top   = (next_fresh < count) ? next_fresh : count;
        roll  = $urandom_range(0, 99);
        op    = OP_ACK;
        seq   = SEQ_W'($urandom);
        bad   = 1'b1;
        if (roll < 45)
        begin
            op  = OP_TICK;
            bad = 1'($urandom_range(0, 1));
            return 1'b1;
        end
        if (roll < 85 && top > oldest_unacked)
        begin
            reach = top - oldest_unacked - 1;
            if (reach > 2)
                reach = 2;
            seq = SEQ_W'(oldest_unacked + $urandom_range(0, reach));
            bad = 1'b0;
            return 1'b1;
        end
        roll = $urandom_range(0, 2);
        if (roll == 1 && oldest_unacked > 0)
        begin
            seq = SEQ_W'($urandom_range(0, oldest_unacked - 1));
            bad = 1'b0;
        end
        else if (roll == 2 && count < MAX_PACKETS)
        begin
            seq = SEQ_W'($urandom_range(count, MAX_PACKETS - 1));
            bad = 1'b0;
        end
        return 1'b0;
    endfunction

    task automatic push_item(logic op, logic [SEQ_W-1:0] seq, logic bad);
        in_valid    <= 1'b1;
        operation   <= op;
        ack_seq     <= seq;
        ack_corrupt <= bad;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_window(op, seq, bad);
    endtask

    task automatic queue_step();
        foreach (step_sends[j])
            pending_sends.push_back(step_sends[j]);
    endtask

    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            in_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
            begin
                @(posedge clk);
                while (pending_sends.size() != 0)
                    @(posedge clk);
            end
            else
                repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_sends.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WINDOW_SIZE:   win_cfg = val[WIN_W-1:0];
            CFG_TIMEOUT_TICKS: tmo_cfg = val[TMO_W-1:0];
            CFG_PACKET_COUNT:  cnt_cfg = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic retune(bit all);
        int unsigned roll;
        int unsigned val;
        if (all || $urandom_range(0, 1) == 1)
        begin
            roll = $urandom_range(0, 9);
            case (roll)
                0:       val = 0;
                1:       val = $urandom_range(MAX_WINDOW + 1, 63);
                2:       val = 1;
                3:       val = MAX_WINDOW;
                default: val = $urandom_range(2, 12);
            endcase
            write_reg(CFG_WINDOW_SIZE, CFG_W'(val));
        end
        if (all || $urandom_range(0, 1) == 1)
        begin
            roll = $urandom_range(0, 9);
            case (roll)
                0:       val = 65535;
                1:       val = 1;
                default: val = $urandom_range(2, 8);
            endcase
            write_reg(CFG_TIMEOUT_TICKS, CFG_W'(val));
        end
        roll = $urandom_range(0, 11);
        if (roll == 0)
            val = 0;
        else if (roll == 1)
            val = $urandom_range(MAX_PACKETS + 1, 511);
        else if (roll == 2 && oldest_unacked > 0)
            val = $urandom_range(0, oldest_unacked - 1);
        else
        begin
            val = oldest_unacked + $urandom_range(1, 24);
            if (val > MAX_PACKETS)
                val = MAX_PACKETS;
        end
        write_reg(CFG_PACKET_COUNT, CFG_W'(val));
    endtask

    // output side: stall pattern
    initial
    begin : stall_pattern
        stall_mode_t mode;
        int unsigned span;
        int unsigned beat;
        out_stall <= 1'b0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            for (beat = 0; beat < span; beat++)
            begin
                @(posedge clk);
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= (beat % 4 != 3);
                endcase
            end
        end
    end

    // output check and watchdog
    always @(posedge clk)
    begin : check_sends
        send_rec_t got;
        send_rec_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                got.sv   = send_valid;
                got.seq  = send_seq;
                got.rt   = is_retransmit;
                got.base = window_base;
                got.done = all_done;
                got.last = last;
                if (pending_sends.size() == 0)
                begin
                    fail_count++;
                    if (shown < SHOW_MAX)
                    begin
                        shown++;
                        $display("%0t: unexpected transfer: valid %0b seq %0d retx %0b",
                                 $time, got.sv, got.seq, got.rt);
                    end
                end
                else
                begin
                    want = pending_sends.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (shown < SHOW_MAX)
                        begin
                            shown++;
                            $display("%0t: mismatch exp valid %0b seq %0d retx %0b base %0d",
                                     $time, want.sv, want.seq, want.rt, want.base);
                            $display("    done %0b last %0b / got valid %0b seq %0d retx %0b",
                                     want.done, want.last, got.sv, got.seq, got.rt);
                            $display("    base %0d done %0b last %0b",
                                     got.base, got.done, got.last);
                        end
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        send_rec_t        quiet_rec;
        logic             op;
        logic             bad;
        logic [SEQ_W-1:0] seq;
        int unsigned      counted;
        bit               first;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_WINDOW_SIZE;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        operation   <= OP_TICK;
        ack_seq     <= '0;
        ack_corrupt <= 1'b0;
        win_cfg        = WINDOW_SIZE_RST;
        tmo_cfg        = TIMEOUT_TICKS_RST;
        cnt_cfg        = PACKET_COUNT_RST;
        oldest_unacked = 0;
        next_fresh     = 0;
        tick_now       = '0;
        fail_count     = 0;
        shown          = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        foreach (in_air[i])
        begin
            in_air[i]   = 1'b0;
            due_tick[i] = '0;
        end

        plan.push_back(item_row(OP_TICK, 0, 1'b0));
        plan.push_back(quiet_row(OP_ACK, 2, 1'b1, 0, 1'b0));    // corrupt
        plan.push_back(quiet_row(OP_ACK, 255, 1'b0, 0, 1'b0));  // past packet_count
        plan.push_back(item_row(OP_ACK, 3, 1'b0));
        plan.push_back(quiet_row(OP_ACK, 0, 1'b0, 4, 1'b0));    // below base
        plan.push_back(write_row(CFG_TIMEOUT_TICKS, 1));
        plan.push_back(item_row(OP_ACK, 7, 1'b0));
        plan.push_back(quiet_row(OP_TICK, 0, 1'b0, 8, 1'b0));   // deadline reached, not passed
        plan.push_back(item_row(OP_TICK, 0, 1'b0));
        plan.push_back(quiet_row(OP_ACK, 9, 1'b0, 10, 1'b1));   // session complete
        plan.push_back(write_row(CFG_PACKET_COUNT, 0));
        plan.push_back(quiet_row(OP_TICK, 0, 1'b0, 10, 1'b1));
        plan.push_back(write_row(CFG_PACKET_COUNT, 300));
        plan.push_back(write_row(CFG_WINDOW_SIZE, 0));
        plan.push_back(quiet_row(OP_TICK, 255, 1'b1, 10, 1'b0));
        plan.push_back(quiet_row(OP_ACK, 12, 1'b0, 13, 1'b0));  // ahead of next_seq
        plan.push_back(write_row(CFG_WINDOW_SIZE, 63));
        plan.push_back(item_row(OP_TICK, 0, 1'b0));
        plan.push_back(item_row(OP_ACK, 40, 1'b0));
        plan.push_back(write_row(CFG_PACKET_COUNT, 20));
        plan.push_back(quiet_row(OP_TICK, 0, 1'b0, 41, 1'b1));  // count below base
        plan.push_back(write_row(CFG_PACKET_COUNT, 256));
        plan.push_back(write_row(CFG_WINDOW_SIZE, 32));
        plan.push_back(write_row(CFG_TIMEOUT_TICKS, 65535));
        plan.push_back(item_row(OP_TICK, 0, 1'b0));
        plan.push_back(item_row(OP_ACK, 50, 1'b0));
        plan.push_back(write_row(CFG_WINDOW_SIZE, 1));
        plan.push_back(quiet_row(OP_TICK, 0, 1'b0, 51, 1'b0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_WRITE)
                write_reg(plan[k].idx, plan[k].val);
            else
            begin
                push_item(plan[k].op, plan[k].seq, plan[k].bad);
                if (plan[k].quiet)
                begin
                    quiet_rec      = '0;
                    quiet_rec.base = plan[k].base;
                    quiet_rec.done = plan[k].done;
                    quiet_rec.last = 1'b1;
                    pending_sends.push_back(quiet_rec);
                end
                else
                    queue_step();
                pace();
            end
        end

        counted = 0;
        first   = 1'b1;
        while (counted < RANDOM_ITEMS)
        begin
            retune(first);
            first = 1'b0;
            repeat ($urandom_range(6, 18))
            begin
                void'(pick_item(op, seq, bad));
                counted++;
                push_item(op, seq, bad);
                queue_step();
                pace();
            end
        end

        in_valid <= 1'b0;
        while (pending_sends.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/gbn_pkg.sv
rtl/gbn_deadline_ram.sv
rtl/go_back_n_sender_window.sv
sim/go_back_n_sender_window_tb.sv
